/* rtl/core/feeder_motor_heat_stall_controller_core_assert.svh */
// Assertion macros used by the feeder controller back end.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef FEEDER_MOTOR_HEAT_STALL_CONTROLLER_CORE_ASSERT_SVH
`define FEEDER_MOTOR_HEAT_STALL_CONTROLLER_CORE_ASSERT_SVH

// Property checked at every rising edge, off while reset is asserted.
`define FMHSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be seen.
`define FMHSC_NEVER(label, cond, msg) \
  `FMHSC_ASSERT(label, !(cond), msg)

`endif

/* rtl/core/fmhsc_pkg.sv */
// Types and constants of the feeder motor controller.
// No dependencies; imported by every module of the block.
package fmhsc_pkg;

  typedef enum logic [1:0] {
    MODE_OTHER  = 2'd0,
    MODE_REMOTE = 2'd1,
    MODE_AIM    = 2'd2
  } control_mode_e;

  typedef enum logic [2:0] {
    CFG_GAIN_P        = 3'd0,
    CFG_GAIN_I        = 3'd1,
    CFG_GAIN_D        = 3'd2,
    CFG_FEED_SPEED    = 3'd3,
    CFG_CURRENT_LIMIT = 3'd4
  } cfg_index_e;

  // Register reset values
  localparam logic [15:0]        GainPReset        = 16'd24576;
  localparam logic [15:0]        GainIReset        = 16'd90;
  localparam logic [15:0]        GainDReset        = 16'd0;
  localparam logic signed [13:0] FeedSpeedReset    = -14'sd5500;
  localparam logic [13:0]        CurrentLimitReset = 14'd10000;

  // Heat hysteresis thresholds
  localparam logic [15:0] RefHeatHigh = 16'd280;
  localparam logic [15:0] RefHeatLow  = 16'd120;
  localparam logic [14:0] EstHeatHigh = 15'd800;
  localparam logic [14:0] EstHeatLow  = 15'd10;
  localparam logic [14:0] EstHeatMax  = 15'd32767;

  // Stall detection and PID limits
  localparam logic signed [15:0] SlowSpeed    = 16'sd100;
  localparam logic signed [14:0] StallDrive   = 15'sd10000;
  localparam logic signed [17:0] ErrorSumMax  = 18'sd15000;
  localparam logic signed [13:0] FeedMostNeg  = -14'sd8192;
  localparam logic signed [13:0] FeedMostPos  = 14'sd8191;

  // Front-to-back queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [13:0] feed_speed;
    logic [13:0]        current_limit;
  } fmhsc_cfg_t;

  // One tick after decode
  typedef struct packed {
    logic               remote_feed;  // remote mode asking to feed
    logic               aim_gate;     // auto-aim, tracking, shooter powered
    logic               running_fire;
    logic               ref_lim;
    logic               heat_hi;      // referee heat at or above high mark
    logic               heat_lo;      // referee heat at or below low mark
    logic               fric_stop;
    logic               slow;         // |speed| below stall threshold
    logic signed [15:0] measured;
  } fmhsc_item_t;

endpackage

/* rtl/core/feeder_motor_heat_stall_controller_core.sv */
// Feeder motor controller: heat limit, stall reversal and speed PID.
// Top level; uses fmhsc_pkg, fmhsc_front, fmhsc_queue and fmhsc_back.
//
// Usage:
//  - One input transfer per control tick (in_valid_i / in_stall_o) carries
//    mode flags, referee heat and measured speed. One output transfer
//    (out_valid_o / out_stall_i) returns drive current, commanded speed and
//    the heat flag for that tick, in order.
//  - A tick passes the queue entry, then the control stage, then the PID/clamp
//    stage into the output register.
//  - Throughput: one transfer per cycle while the output is not stalled. A tick whose
//    speed is within +-99 while no reversal runs waits until the previous tick
//    has left the PID stage, since stall detection looks at its drive.
//  - The output register decouples the sides: while out_stall_i holds a
//    result, the PID stage and the two-entry queue keep filling before
//    in_stall_o rises.
//  - Reset clears all control state, the queue pointers and the output valid flag
//    and loads the gain, feed speed and current limit reset values.
//  - Config writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered before they
//    take effect; unknown indexes are ignored. Write only while the block is idle.
module feeder_motor_heat_stall_controller_core #(
  parameter int unsigned STALL_TICKS   = 20,
  parameter int unsigned REVERSE_TICKS = 60,
  parameter int unsigned BURST_TICKS   = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         control_mode_i,
  input  logic               feed_requested_i,
  input  logic               target_tracked_i,
  input  logic               shooter_power_i,
  input  logic               running_fire_i,
  input  logic               referee_limit_active_i,
  input  logic [15:0]        referee_heat_i,
  input  logic               friction_stopped_i,
  input  logic signed [15:0] measured_speed_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] drive_current_o,
  output logic signed [13:0] commanded_speed_o,
  output logic               heat_ok_o
);
  import fmhsc_pkg::*;

  fmhsc_cfg_t  cfg_q, cfg_d;
  fmhsc_item_t front_item, head_item;
  logic        q_full, q_valid, q_push, q_pop;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAIN_P:        cfg_d.gain_p        = cfg_data_i;
        CFG_GAIN_I:        cfg_d.gain_i        = cfg_data_i;
        CFG_GAIN_D:        cfg_d.gain_d        = cfg_data_i;
        CFG_FEED_SPEED:    cfg_d.feed_speed    = signed'(cfg_data_i[13:0]);
        CFG_CURRENT_LIMIT: cfg_d.current_limit = cfg_data_i[13:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= GainPReset;
      cfg_q.gain_i        <= GainIReset;
      cfg_q.gain_d        <= GainDReset;
      cfg_q.feed_speed    <= FeedSpeedReset;
      cfg_q.current_limit <= CurrentLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: decode each accepted tick straight into the queue
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  fmhsc_front u_front (
    .control_mode_i         (control_mode_i),
    .feed_requested_i       (feed_requested_i),
    .target_tracked_i       (target_tracked_i),
    .shooter_power_i        (shooter_power_i),
    .running_fire_i         (running_fire_i),
    .referee_limit_active_i (referee_limit_active_i),
    .referee_heat_i         (referee_heat_i),
    .friction_stopped_i     (friction_stopped_i),
    .measured_speed_i       (measured_speed_i),
    .item_o                 (front_item)
  );

  fmhsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head_item)
  );

  // Back: control state, PID and output register
  fmhsc_back #(
    .StallTicks   (STALL_TICKS),
    .ReverseTicks (REVERSE_TICKS),
    .BurstTicks   (BURST_TICKS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .head_i            (head_item),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .drive_current_o   (drive_current_o),
    .commanded_speed_o (commanded_speed_o),
    .heat_ok_o         (heat_ok_o)
  );

endmodule

/* rtl/core/fmhsc_front.sv */
// Front end: decodes one control tick into the queue entry format.
// Depends on fmhsc_pkg.
module fmhsc_front (
  input  logic [1:0]               control_mode_i,
  input  logic                     feed_requested_i,
  input  logic                     target_tracked_i,
  input  logic                     shooter_power_i,
  input  logic                     running_fire_i,
  input  logic                     referee_limit_active_i,
  input  logic [15:0]              referee_heat_i,
  input  logic                     friction_stopped_i,
  input  logic signed [15:0]       measured_speed_i,
  output fmhsc_pkg::fmhsc_item_t   item_o
);
  import fmhsc_pkg::*;

  always_comb begin
    item_o.remote_feed  = (control_mode_i == MODE_REMOTE) && feed_requested_i;
    item_o.aim_gate     = (control_mode_i == MODE_AIM) && target_tracked_i &&
                          shooter_power_i;
    item_o.running_fire = running_fire_i;
    item_o.ref_lim      = referee_limit_active_i;
    item_o.heat_hi      = referee_heat_i >= RefHeatHigh;
    item_o.heat_lo      = referee_heat_i <= RefHeatLow;
    item_o.fric_stop    = friction_stopped_i;
    item_o.slow         = (measured_speed_i < SlowSpeed) && (measured_speed_i > -SlowSpeed);
    item_o.measured     = measured_speed_i;
  end

endmodule

/* rtl/core/fmhsc_queue.sv */
// Two-entry queue between the decode front and the control back end.
// Depends on fmhsc_pkg.
module fmhsc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fmhsc_pkg::fmhsc_item_t item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output fmhsc_pkg::fmhsc_item_t head_o
);
  import fmhsc_pkg::*;

  fmhsc_item_t       entries_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign full_o  = count_q == QCntW'(QDepth);
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/fmhsc_back.sv */
// Back end: heat/target/stall control (stage 1), PID products, clamp and
// output register (stage 2). Depends on fmhsc_pkg and the assert macros.
module fmhsc_back #(
  parameter int unsigned StallTicks   = 20,
  parameter int unsigned ReverseTicks = 60,
  parameter int unsigned BurstTicks   = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fmhsc_pkg::fmhsc_cfg_t  cfg_i,
  input  logic                   q_valid_i,
  input  fmhsc_pkg::fmhsc_item_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [14:0]     drive_current_o,
  output logic signed [13:0]     commanded_speed_o,
  output logic                   heat_ok_o
);
  import fmhsc_pkg::*;
  `include "feeder_motor_heat_stall_controller_core_assert.svh"

  // control state
  logic               heat_allowed_q, heat_allowed_d;
  logic [14:0]        heat_est_q, heat_est_d;
  logic [3:0]         burst_q, burst_d;
  logic [4:0]         stall_q, stall_d;
  logic [5:0]         reverse_q, reverse_d;
  logic signed [16:0] prev_err_q;
  logic signed [14:0] esum_q, esum_d;
  logic               prev_at_limit_q;

  // stage 2 and output
  logic               s2_valid_q;
  logic signed [16:0] s2_err_q;
  logic signed [14:0] s2_esum_q;
  logic signed [17:0] s2_derr_q;
  logic signed [13:0] s2_tgt_q;
  logic               s2_heat_q;
  logic               out_valid_q;
  logic signed [14:0] drive_q;
  logic signed [13:0] cmd_q;
  logic               heat_q;

  logic               out_free, out_load, s2_ready, hazard;
  logic               feed_sel;
  logic [4:0]         stall_inc;
  logic [5:0]         reverse_mid;
  logic signed [13:0] neg_feed, tgt;
  logic [15:0]        est_inc;
  logic signed [16:0] err;
  logic signed [17:0] derr, esum_raw;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = s2_valid_q && out_free;
  assign s2_ready = !s2_valid_q || out_free;
  // A slow tick outside reversal needs the previous drive, which is still
  // in stage 2 when s2_valid_q is set.
  assign hazard   = head_i.slow && (reverse_q == '0) && s2_valid_q;
  assign pop_o    = q_valid_i && s2_ready && !hazard;

  // ---------------- stage 1: control ----------------
  always_comb begin
    heat_allowed_d = heat_allowed_q;
    if (head_i.ref_lim) begin
      if (head_i.heat_hi) begin
        heat_allowed_d = 1'b0;
      end else if (head_i.heat_lo) begin
        heat_allowed_d = 1'b1;
      end
    end else begin
      if (heat_est_q > EstHeatHigh) begin
        heat_allowed_d = 1'b0;
      end
      if (heat_est_q < EstHeatLow) begin
        heat_allowed_d = 1'b1;
      end
    end

    feed_sel = 1'b0;
    burst_d  = burst_q;
    if (head_i.remote_feed && heat_allowed_d) begin
      feed_sel = 1'b1;
    end else if (head_i.aim_gate && heat_allowed_d) begin
      if (head_i.running_fire) begin
        feed_sel = 1'b1;
        burst_d  = '0;
      end else if (burst_q <= 4'(BurstTicks)) begin
        feed_sel = 1'b1;
        burst_d  = burst_q + 1'b1;
      end
    end

    stall_d     = stall_q;
    reverse_mid = reverse_q;
    stall_inc   = stall_q + 1'b1;
    if (reverse_q == '0) begin
      stall_d = (head_i.slow && prev_at_limit_q) ? stall_inc : '0;
      if (stall_d >= 5'(StallTicks)) begin
        reverse_mid = 6'(ReverseTicks);
        stall_d     = '0;
      end
    end

    neg_feed  = (cfg_i.feed_speed == FeedMostNeg) ? FeedMostPos : -cfg_i.feed_speed;
    tgt       = feed_sel ? cfg_i.feed_speed : '0;
    reverse_d = reverse_mid;
    if (reverse_mid != '0) begin
      reverse_d = reverse_mid - 1'b1;
      tgt       = neg_feed;
    end
    if (!heat_allowed_d) begin
      tgt = '0;
    end

    est_inc    = {1'b0, heat_est_q} + 16'd2;
    heat_est_d = heat_est_q;
    if (tgt != '0) begin
      heat_est_d = (est_inc > {1'b0, EstHeatMax}) ? EstHeatMax : est_inc[14:0];
    end else if (heat_est_q >= EstHeatLow) begin
      heat_est_d = heat_est_q - 15'd2;
    end

    if (head_i.fric_stop) begin
      tgt = '0;
    end

    err      = {{3{tgt[13]}}, tgt} - {head_i.measured[15], head_i.measured};
    derr     = {err[16], err} - {prev_err_q[16], prev_err_q};
    esum_raw = {{3{esum_q[14]}}, esum_q} + {err[16], err};
    if (esum_raw > ErrorSumMax) begin
      esum_d = ErrorSumMax[14:0];
    end else if (esum_raw < -ErrorSumMax) begin
      esum_d = -ErrorSumMax[14:0];
    end else begin
      esum_d = esum_raw[14:0];
    end
  end

  // ---------------- stage 2: PID output ----------------
  logic signed [16:0] gp_s, gi_s, gd_s;
  logic signed [33:0] prod_p;
  logic signed [31:0] prod_i;
  logic signed [34:0] prod_d;
  logic signed [36:0] acc, acc_adj;
  logic signed [24:0] quo, lim;
  logic signed [14:0] drive;

  always_comb begin
    gp_s    = signed'({1'b0, cfg_i.gain_p});
    gi_s    = signed'({1'b0, cfg_i.gain_i});
    gd_s    = signed'({1'b0, cfg_i.gain_d});
    prod_p  = gp_s * s2_err_q;
    prod_i  = gi_s * s2_esum_q;
    prod_d  = gd_s * s2_derr_q;
    acc     = {{3{prod_p[33]}}, prod_p} + {{5{prod_i[31]}}, prod_i} +
              {{2{prod_d[34]}}, prod_d};
    // divide by 4096, truncating toward zero
    acc_adj = acc + (acc[36] ? 37'sd4095 : 37'sd0);
    quo     = acc_adj[36:12];
    lim     = signed'({11'b0, cfg_i.current_limit});
    if (quo > lim) begin
      drive = lim[14:0];
    end else if (quo < -lim) begin
      drive = -lim[14:0];
    end else begin
      drive = quo[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_allowed_q  <= 1'b0;
      heat_est_q      <= '0;
      burst_q         <= '0;
      stall_q         <= '0;
      reverse_q       <= '0;
      prev_err_q      <= '0;
      esum_q          <= '0;
      prev_at_limit_q <= 1'b0;
      s2_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        heat_allowed_q <= heat_allowed_d;
        heat_est_q     <= heat_est_d;
        burst_q        <= burst_d;
        stall_q        <= stall_d;
        reverse_q      <= reverse_d;
        prev_err_q     <= err;
        esum_q         <= esum_d;
      end
      if (out_load) begin
        prev_at_limit_q <= (drive == StallDrive) || (drive == -StallDrive);
      end
      if (pop_o) begin
        s2_valid_q <= 1'b1;
      end else if (out_load) begin
        s2_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_err_q  <= err;
      s2_esum_q <= esum_d;
      s2_derr_q <= derr;
      s2_tgt_q  <= tgt;
      s2_heat_q <= heat_allowed_d;
    end
    if (out_load) begin
      drive_q <= drive;
      cmd_q   <= s2_tgt_q;
      heat_q  <= s2_heat_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_current_o   = drive_q;
  assign commanded_speed_o = cmd_q;
  assign heat_ok_o         = heat_q;

  `FMHSC_ASSERT(a_esum_range, (esum_q <= 15'sd15000) && (esum_q >= -15'sd15000), "error sum out of range")
  `FMHSC_ASSERT(a_rev_no_stall, (reverse_q != '0) |-> (stall_q == '0), "stall count during reversal")
  `FMHSC_ASSERT(a_burst_max, burst_q <= 4'(BurstTicks + 1), "burst count overran")
  `FMHSC_ASSERT(a_s2_hold, (s2_valid_q && out_valid_q && out_stall_i) |=> s2_valid_q, "stage 2 lost")

endmodule

/* sim/tb.sv */
// Testbench for feeder_motor_heat_stall_controller_core: heat limit, stall reversal, speed PID.
// Self-contained; needs only the RTL (fmhsc_pkg and the core with its submodules).
// A scoreboard class predicts every output transfer and checks it in order.
`timescale 1ns / 100ps

module tb;
  import fmhsc_pkg::*;

  localparam int StallTicks   = 20;
  localparam int ReverseTicks = 60;
  localparam int BurstTicks   = 10;

  // Limits of the control law, taken over from the package as plain ints
  localparam int RefHot      = RefHeatHigh;
  localparam int RefCool     = RefHeatLow;
  localparam int EstHot      = EstHeatHigh;
  localparam int EstCool     = EstHeatLow;
  localparam int EstTop      = EstHeatMax;
  localparam int HeatStep    = 2;
  localparam int SlowLimit   = SlowSpeed;
  localparam int StallLevel  = StallDrive;
  localparam int SumLimit    = ErrorSumMax;
  localparam int FeedTop     = FeedMostPos;
  localparam int Q12One      = 4096;

  localparam logic [1:0] ModeUnused     = 2'd3;
  localparam logic [2:0] CfgUnusedFirst = 3'd5;
  localparam logic [2:0] CfgUnusedLast  = 3'd7;

  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 165;
  localparam int DrainCycles   = 12;
  localparam int MaxReports    = 10;
  localparam int HoldCycles    = 80;
  localparam int HoldEvery     = 700;
  localparam longint TimeoutNs = 2_000_000;

  // One control tick as it crosses the input channel
  typedef struct packed {
    logic [1:0]         mode;
    logic               feed_req;
    logic               tracked;
    logic               power;
    logic               running;
    logic               ref_lim;
    logic [15:0]        ref_heat;
    logic               fric_stop;
    logic signed [15:0] speed;
  } tick_t;

  localparam int TickBits = $bits(tick_t);

  // One result as it crosses the output channel
  typedef struct packed {
    logic signed [14:0] drive;
    logic signed [13:0] speed;
    logic               heat_ok;
  } drive_t;

  typedef enum {PROF_NOISE, PROF_REMOTE, PROF_STALL, PROF_AIM, PROF_COOL} profile_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_e;

  // Keeps its own copy of the registers and loop state, predicts each tick's
  // result and compares output transfers against them in order.
  class heat_loop_scoreboard;
    int gain_p, gain_i, gain_d, feed, limit;
    bit heat_on;
    int heat_level, burst_used, slow_ticks, reverse_left;
    int last_err, err_integral, last_drive;
    drive_t pending[$];
    int checked, mismatches;

    function new();
      gain_p = GainPReset;
      gain_i = GainIReset;
      gain_d = GainDReset;
      feed   = FeedSpeedReset;
      limit  = CurrentLimitReset;
    endfunction

    function void load_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_GAIN_P:        gain_p = data;
        CFG_GAIN_I:        gain_i = data;
        CFG_GAIN_D:        gain_d = data;
        CFG_FEED_SPEED:    feed = int'(signed'(data[13:0]));
        CFG_CURRENT_LIMIT: limit = data[13:0];
        default: ;  // unknown index, dropped
      endcase
    endfunction

    static function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    function drive_t drive_for_tick(tick_t t);
      int target, meas, err, derr;
      longint acc;
      drive_t r;
      target = 0;
      meas = int'(t.speed);

      // heat hysteresis
      if (t.ref_lim) begin
        if (int'(t.ref_heat) >= RefHot) heat_on = 1'b0;
        else if (int'(t.ref_heat) <= RefCool) heat_on = 1'b1;
      end else begin
        if (heat_level > EstHot) heat_on = 1'b0;
        if (heat_level < EstCool) heat_on = 1'b1;
      end

      // target selection, auto-aim keeps feeding a short burst after running fire
      if (t.mode == MODE_REMOTE) begin
        if (t.feed_req && heat_on) target = feed;
      end else if (t.mode == MODE_AIM && t.tracked && t.power && heat_on) begin
        if (t.running) begin
          target = feed;
          burst_used = 0;
        end else if (burst_used <= BurstTicks) begin
          target = feed;
          burst_used = (burst_used + 1) & 'hF;
        end
      end

      // stall detection on the previous drive, then reversal
      if (reverse_left == 0) begin
        if (mag(meas) < SlowLimit && mag(last_drive) == StallLevel)
          slow_ticks = (slow_ticks + 1) & 'h1F;
        else
          slow_ticks = 0;
        if (slow_ticks >= StallTicks) begin
          reverse_left = ReverseTicks;
          slow_ticks = 0;
        end
      end
      if (reverse_left > 0) begin
        reverse_left--;
        target = -feed;
        if (target > FeedTop) target = FeedTop;
      end

      if (!heat_on) target = 0;

      if (target != 0) begin
        heat_level += HeatStep;
        if (heat_level > EstTop) heat_level = EstTop;
      end else if (heat_level >= EstCool) begin
        heat_level -= HeatStep;
      end

      if (t.fric_stop) target = 0;

      // PID with clamped integral, Q4.12 gains, truncation toward zero
      err = target - meas;
      derr = err - last_err;
      err_integral += err;
      if (err_integral > SumLimit) err_integral = SumLimit;
      if (err_integral < -SumLimit) err_integral = -SumLimit;
      acc = longint'(gain_p) * err + longint'(gain_i) * err_integral
          + longint'(gain_d) * derr;
      acc = acc / Q12One;
      if (acc > limit) acc = limit;
      if (acc < -limit) acc = -limit;

      last_err = err;
      last_drive = int'(acc);
      r.drive = 15'(acc);
      r.speed = 14'(target);
      r.heat_ok = heat_on;
      return r;
    endfunction

    function void note_tick(tick_t t);
      pending.push_back(drive_for_tick(t));
    endfunction

    function void flag(string field, int want, int seen);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("result %0d: %s expected %0d, got %0d", checked, field, want, seen);
    endfunction

    function void check_result(drive_t seen);
      drive_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result %0d: output transfer with no tick pending", checked);
        return;
      end
      want = pending.pop_front();
      if (seen.drive !== want.drive) flag("drive_current", want.drive, seen.drive);
      if (seen.speed !== want.speed) flag("commanded_speed", want.speed, seen.speed);
      if (seen.heat_ok !== want.heat_ok) flag("heat_ok", want.heat_ok, seen.heat_ok);
    endfunction
  endclass

  heat_loop_scoreboard sb = new();

  // ---------------------------------------------------------------------------
  // Clock, reset and block signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tick_t       cur = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [14:0] drive_current;
  logic signed [13:0] commanded_speed;
  logic        heat_ok;
  drive_t      got;

  always #4 clk = ~clk;

  feeder_motor_heat_stall_controller_core #(
    .STALL_TICKS  (StallTicks),
    .REVERSE_TICKS(ReverseTicks),
    .BURST_TICKS  (BurstTicks)
  ) dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_index_i           (cfg_index),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .control_mode_i        (cur.mode),
    .feed_requested_i      (cur.feed_req),
    .target_tracked_i      (cur.tracked),
    .shooter_power_i       (cur.power),
    .running_fire_i        (cur.running),
    .referee_limit_active_i(cur.ref_lim),
    .referee_heat_i        (cur.ref_heat),
    .friction_stopped_i    (cur.fric_stop),
    .measured_speed_i      (cur.speed),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .drive_current_o       (drive_current),
    .commanded_speed_o     (commanded_speed),
    .heat_ok_o             (heat_ok)
  );

  // ---------------------------------------------------------------------------
  // Output side: a random stall pattern is picked for each stretch, including
  // stretches with no stall at all. Every HoldEvery results the receiver holds
  // off long enough that the pipe and queue fill and in_stall rises.
  // ---------------------------------------------------------------------------
  int           hold_left = 0;
  int           next_hold_at = 300;
  int           pattern_left = 0;
  stall_style_e stall_style = STALL_NONE;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (sb.checked >= next_hold_at) begin
      next_hold_at += HoldEvery;
      hold_left = HoldCycles - 1;
      out_stall = 1'b1;
    end else begin
      if (pattern_left == 0) begin
        stall_style = stall_style_e'($urandom_range(3, 0));
        pattern_left = $urandom_range(200, 20);
      end
      pattern_left--;
      case (stall_style)
        STALL_NONE:   out_stall = 1'b0;
        STALL_LIGHT:  out_stall = ($urandom_range(3, 0) == 0);
        STALL_HEAVY:  out_stall = ($urandom_range(3, 0) != 0);
        STALL_TOGGLE: out_stall = ~out_stall;
        default:      out_stall = 1'b0;
      endcase
    end
  end

  // Output transfers are checked at the rising edge they happen on
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.drive = drive_current;
      got.speed = commanded_speed;
      got.heat_ok = heat_ok;
      sb.check_result(got);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: bursts of random length with random gaps, unless the phase
  // runs steady. Payload changes only at the falling edge after a transfer.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit sender_steady = 1'b0;

  task automatic send_tick(tick_t t);
    cur = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_tick(t);
    @(negedge clk);
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        if ($urandom_range(7, 0) == 0) repeat ($urandom_range(30, 8)) @(negedge clk);
        else repeat ($urandom_range(5, 1)) @(negedge clk);
        burst_left = $urandom_range(24, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.load_register(idx, data);
  endtask

  // Block is idle once every predicted result has left; ends on a falling edge
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic tick_t mk_tick(logic [1:0] mode, bit fr, bit tr, bit pw, bit rf,
                                    bit rl, logic [15:0] heat, bit fs,
                                    logic signed [15:0] spd);
    tick_t t;
    t.mode = mode;
    t.feed_req = fr;
    t.tracked = tr;
    t.power = pw;
    t.running = rf;
    t.ref_lim = rl;
    t.ref_heat = heat;
    t.fric_stop = fs;
    t.speed = spd;
    return t;
  endfunction

  // Measured speed: near standstill, around the stall window edge, normal
  // feeding range, or anything the field holds
  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(3, 0))
      0: return 16'(int'($urandom_range(198, 0)) - 99);
      1: return ($urandom_range(1, 0) != 0) ? 16'(int'($urandom_range(101, 98)))
                                            : 16'(-int'($urandom_range(101, 98)));
      2: return 16'(int'($urandom_range(16000, 0)) - 8000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Referee heat around both hysteresis marks, or any value
  function automatic logic [15:0] pick_heat();
    case ($urandom_range(3, 0))
      0: return 16'($urandom_range(RefCool, 0));
      1: return 16'($urandom_range(RefHot - 1, RefCool + 1));
      2: return 16'($urandom_range(RefHot + 120, RefHot));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tick_t scenario_tick(profile_e p, int step);
    tick_t t;
    t = tick_t'(TickBits'({$urandom, $urandom}));  // noise baseline, every bit random
    case (p)
      PROF_REMOTE: begin
        t.mode = MODE_REMOTE;
        t.feed_req = ($urandom_range(15, 0) != 0);
        t.ref_lim = ($urandom_range(7, 0) == 0);
        t.ref_heat = pick_heat();
        t.fric_stop = ($urandom_range(15, 0) == 0);
        t.speed = pick_speed();
      end
      PROF_STALL: begin
        // feeding against a jammed rotor; an odd fast tick breaks the count
        t.mode = MODE_REMOTE;
        t.feed_req = 1'b1;
        t.ref_lim = 1'b1;
        t.ref_heat = 16'($urandom_range(RefCool, 0));
        t.fric_stop = 1'b0;
        t.speed = ($urandom_range(24, 0) == 0) ? pick_speed()
                                                : 16'(int'($urandom_range(198, 0)) - 99);
      end
      PROF_AIM: begin
        // short running-fire spells, then long enough without to use up the burst
        t.mode = MODE_AIM;
        t.tracked = ($urandom_range(9, 0) != 0);
        t.power = ($urandom_range(9, 0) != 0);
        t.running = ((step % 24) < 6) ^ ($urandom_range(9, 0) == 0);
        t.ref_lim = ($urandom_range(3, 0) == 0);
        t.ref_heat = pick_heat();
        t.fric_stop = ($urandom_range(15, 0) == 0);
        t.speed = pick_speed();
      end
      PROF_COOL: begin
        t.mode = ($urandom_range(1, 0) != 0) ? MODE_OTHER : MODE_REMOTE;
        t.feed_req = 1'b0;
        t.ref_lim = 1'b0;
        t.speed = pick_speed();
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic run_phase(int quota);
    profile_e p;
    int len, sent, step;
    sent = 0;
    sender_steady = ($urandom_range(3, 0) == 0);
    while (sent < quota) begin
      case ($urandom_range(9, 0))
        0, 1:    begin p = PROF_NOISE;  len = $urandom_range(20, 1);  end
        2, 3, 4: begin p = PROF_REMOTE; len = $urandom_range(120, 10); end
        5, 6:    begin p = PROF_STALL;  len = $urandom_range(90, 25); end
        7, 8:    begin p = PROF_AIM;    len = $urandom_range(60, 12); end
        default: begin p = PROF_COOL;   len = $urandom_range(40, 5);  end
      endcase
      for (step = 0; step < len && sent < quota; step++) begin
        send_tick(scenario_tick(p, step));
        sent++;
      end
    end
  endtask

  // Phase settings: both gain extremes, feed speed extremes (the most negative
  // one makes reversal saturate), limit zero and maximum, then random mixes.
  task automatic set_phase_config(int k);
    int gp, gi, gd, fs, cl;
    gp = GainPReset;
    gi = GainIReset;
    gd = GainDReset;
    fs = FeedSpeedReset;
    cl = CurrentLimitReset;
    case (k)
      1: begin gp = 0; gi = 0; gd = 0; fs = 8000; cl = 16000; end
      2: begin gp = 65535; gi = 65535; gd = 65535; fs = -8000; cl = 0; end
      3: fs = -8192;
      4: begin fs = 8191; cl = 16383; gd = $urandom_range(4000, 0); end
      5: begin fs = 0; gd = $urandom_range(65535, 0); end
      default: begin
        gp = ($urandom_range(1, 0) != 0) ? $urandom_range(65535, 0)
                                         : $urandom_range(30000, 16000);
        gi = ($urandom_range(1, 0) != 0) ? $urandom_range(65535, 0) : $urandom_range(400, 0);
        gd = ($urandom_range(1, 0) != 0) ? $urandom_range(65535, 0) : $urandom_range(2000, 0);
        fs = int'($urandom_range(16000, 0)) - 8000;
        cl = ($urandom_range(1, 0) != 0) ? CurrentLimitReset : $urandom_range(16000, 0);
      end
    endcase
    write_reg(CFG_GAIN_P, 16'(gp));
    write_reg(CFG_GAIN_I, 16'(gi));
    write_reg(CFG_GAIN_D, 16'(gd));
    write_reg(CFG_FEED_SPEED, 16'(fs));
    write_reg(CFG_CURRENT_LIMIT, 16'(cl));
    // a write to an unknown index must leave everything alone
    write_reg(3'($urandom_range(CfgUnusedLast, CfgUnusedFirst)), 16'($urandom));
  endtask

  // Directed ticks at reset settings: speed extremes, referee heat on both
  // sides of each mark, every mode, burst after running fire, friction stop
  // while feeding, the stall window edges, and every field bit high at once.
  task automatic run_directed();
    sender_steady = 1'b1;
    send_tick(mk_tick(MODE_OTHER, 0, 0, 0, 0, 0, 16'd0, 0, 16'sd0));
    send_tick(mk_tick(MODE_OTHER, 0, 0, 0, 0, 0, 16'd0, 0, 16'sh7FFF));
    send_tick(mk_tick(MODE_OTHER, 0, 0, 0, 0, 0, 16'd0, 0, 16'sh8000));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd0, 0, 16'sd0));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd120, 0, 16'sd0));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd121, 0, 16'sd50));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd279, 0, 16'sd50));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd280, 0, 16'sd50));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'hFFFF, 0, 16'sd50));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd120, 0, -16'sd3000));
    send_tick(mk_tick(MODE_AIM, 0, 1, 1, 1, 1, 16'd0, 0, -16'sd5000));
    send_tick(mk_tick(MODE_AIM, 0, 1, 1, 0, 1, 16'd0, 0, -16'sd5000));
    send_tick(mk_tick(MODE_AIM, 0, 1, 1, 0, 1, 16'd0, 0, -16'sd5000));
    send_tick(mk_tick(MODE_AIM, 0, 1, 0, 1, 1, 16'd0, 0, 16'sd0));
    send_tick(mk_tick(MODE_AIM, 0, 0, 1, 1, 1, 16'd0, 0, 16'sd0));
    send_tick(mk_tick(ModeUnused, 1, 1, 1, 1, 1, 16'd0, 0, 16'sd0));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd0, 1, 16'sd0));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd0, 0, 16'sd99));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd0, 0, -16'sd99));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd0, 0, 16'sd100));
    send_tick(mk_tick(MODE_REMOTE, 1, 0, 0, 0, 1, 16'd0, 0, -16'sd100));
    send_tick(mk_tick(ModeUnused, 1, 1, 1, 1, 1, 16'hFFFF, 1, -16'sd1));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset once, directed ticks, then random phases with a new
  // register setting written between them while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    wait_drained();
    for (int k = 0; k < NumPhases; k++) begin
      if (k > 0) set_phase_config(k);
      run_phase(ItemsPerPhase);
      wait_drained();
    end

    // catch any stray output transfer after the last expected one
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("simulation failed");
    $finish;
  end

endmodule

/* feeder_motor_heat_stall_controller_core.f */
+incdir+rtl/core
rtl/core/fmhsc_pkg.sv
rtl/core/fmhsc_front.sv
rtl/core/fmhsc_queue.sv
rtl/core/fmhsc_back.sv
rtl/core/feeder_motor_heat_stall_controller_core.sv
sim/tb.sv
